/* hw/rtl/ddm_pkg.sv */
`default_nettype none

package ddm_pkg;

	// fixed-point constants, Q1.14
	localparam logic [14:0] Q_ONE     = 15'd16384;
	localparam logic [14:0] SMALL_CUT = 15'd17;

	// divider runs one quotient bit per step, counting down to zero
	localparam logic [3:0] DIV_LAST = 4'd14;

	// input command codes
	typedef enum logic [1:0] {
		CMD_NEW  = 2'd0,
		CMD_TICK = 2'd1,
		CMD_CTRL = 2'd2
	} cmd_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_LIN_LIMIT = 3'd0,
		REG_ANG_LIMIT = 3'd1,
		REG_PWM_FULL  = 3'd2,
		REG_PWM_FLOOR = 3'd3,
		REG_TIMEOUT   = 3'd4
	} reg_idx_t;

	// datapath operations driven by the control word
	typedef enum logic [3:0] {
		OP_NOP    = 4'd0,
		OP_WAIT   = 4'd1,
		OP_LOAD_V = 4'd2,
		OP_DIV    = 4'd3,
		OP_SAVE_V = 4'd4,
		OP_SAVE_W = 4'd5,
		OP_FLOOR  = 4'd6,
		OP_STOP   = 4'd7,
		OP_EMIT   = 4'd8
	} op_t;

	// jump conditions; a true condition loads the target, else the step advances
	typedef enum logic [2:0] {
		C_NEXT      = 3'd0,
		C_ALWAYS    = 3'd1,
		C_NO_START  = 3'd2,
		C_TIMEOUT   = 3'd3,
		C_DIV_BUSY  = 3'd4,
		C_FLOOR_OFF = 3'd5,
		C_OUT_BUSY  = 3'd6
	} cond_t;

	// program step addresses
	localparam logic [3:0] ST_WAIT   = 4'd0;
	localparam logic [3:0] ST_LOAD_V = 4'd1;
	localparam logic [3:0] ST_DIV_V  = 4'd2;
	localparam logic [3:0] ST_SAVE_V = 4'd3;
	localparam logic [3:0] ST_DIV_W  = 4'd4;
	localparam logic [3:0] ST_SAVE_W = 4'd5;
	localparam logic [3:0] ST_DIV_F  = 4'd6;
	localparam logic [3:0] ST_FLOOR  = 4'd7;
	localparam logic [3:0] ST_EMIT   = 4'd8;
	localparam logic [3:0] ST_RETURN = 4'd9;
	localparam logic [3:0] ST_STOP   = 4'd10;

	typedef struct packed {
		op_t        op;
		cond_t      cond;
		logic [3:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic [14:0] lin_limit;
		logic [14:0] ang_limit;
		logic [7:0]  pwm_full;
		logic [7:0]  pwm_floor;
		logic [15:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic timeout;
		logic div_busy;
		logic floor_off;
	} dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/ddm_urom.sv */
`default_nettype none

module ddm_urom
	import ddm_pkg::*;
(
	input  wire logic [3:0] pc,
	output ctrl_word_t      cw
);

	// control program
	always_comb begin
		case (pc)
			ST_WAIT:   cw = '{op: OP_WAIT,   cond: C_NO_START,  target: ST_WAIT};
			ST_LOAD_V: cw = '{op: OP_LOAD_V, cond: C_TIMEOUT,   target: ST_STOP};
			ST_DIV_V:  cw = '{op: OP_DIV,    cond: C_DIV_BUSY,  target: ST_DIV_V};
			ST_SAVE_V: cw = '{op: OP_SAVE_V, cond: C_NEXT,      target: ST_WAIT};
			ST_DIV_W:  cw = '{op: OP_DIV,    cond: C_DIV_BUSY,  target: ST_DIV_W};
			ST_SAVE_W: cw = '{op: OP_SAVE_W, cond: C_FLOOR_OFF, target: ST_EMIT};
			ST_DIV_F:  cw = '{op: OP_DIV,    cond: C_DIV_BUSY,  target: ST_DIV_F};
			ST_FLOOR:  cw = '{op: OP_FLOOR,  cond: C_NEXT,      target: ST_WAIT};
			ST_EMIT:   cw = '{op: OP_EMIT,   cond: C_OUT_BUSY,  target: ST_EMIT};
			ST_RETURN: cw = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_WAIT};
			ST_STOP:   cw = '{op: OP_STOP,   cond: C_ALWAYS,    target: ST_EMIT};
			default:   cw = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_WAIT};
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/ddm_dp.sv */
`default_nettype none

module ddm_dp
	import ddm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire op_t                op,
	input  wire cfg_t               cfg,
	input  wire logic               in_fire,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [15:0] lin_vel,
	input  wire logic signed [15:0] ang_vel,
	output dp_stat_t                stat,
	output logic                    res_stop,
	output logic signed [15:0]      res_left,
	output logic signed [15:0]      res_right
);

	logic signed [15:0] held_lin_q;
	logic signed [15:0] held_ang_q;
	logic [15:0]        age_q;

	logic [14:0] rem_q;
	logic [14:0] den_q;
	logic [14:0] quo_q;
	logic [3:0]  cnt_q;

	logic signed [15:0] vn_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic               stop_q;

	logic [14:0]        div_a;
	logic [14:0]        div_d;
	logic               div_load;
	logic [15:0]        trial;
	logic               trial_ge;
	logic signed [15:0] vn_new;
	logic signed [15:0] wn_new;
	logic signed [16:0] diff;
	logic signed [16:0] sum;
	logic [14:0]        level;

	// magnitude of a signed speed, clamped to its limit
	function automatic logic [14:0] clamp_mag(input logic signed [15:0] x,
			input logic [14:0] lim);
		logic [15:0] m;
		m = x[15] ? 16'(-x) : 16'(x);
		return (m > {1'b0, lim}) ? lim : m[14:0];
	endfunction

	// signed normalized value from quotient, zero for a zero limit
	function automatic logic signed [15:0] signed_q(input logic neg, input logic [14:0] q,
			input logic [14:0] lim);
		logic signed [15:0] p;
		p = signed'({1'b0, q});
		if (lim == '0)
			return '0;
		return neg ? -p : p;
	endfunction

	// saturate to +-1.0
	function automatic logic signed [15:0] sat_one(input logic signed [16:0] s);
		logic signed [16:0] top;
		top = signed'({2'b00, Q_ONE});
		if (s > top)
			return signed'({1'b0, Q_ONE});
		if (s < -top)
			return -signed'({1'b0, Q_ONE});
		return s[15:0];
	endfunction

	// dead zone and minimum drive
	function automatic logic signed [15:0] apply_floor(input logic signed [15:0] d,
			input logic [14:0] lvl);
		logic [15:0]        m;
		logic signed [15:0] l;
		m = d[15] ? 16'(-d) : 16'(d);
		l = signed'({1'b0, lvl});
		if (m < {1'b0, SMALL_CUT})
			return '0;
		if (m < {1'b0, lvl})
			return d[15] ? -l : l;
		return d;
	endfunction

	// held command and watchdog age
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lin_q <= '0;
			held_ang_q <= '0;
			age_q      <= '0;
		end else if (in_fire) begin
			if (cmd == CMD_NEW) begin
				held_lin_q <= lin_vel;
				held_ang_q <= ang_vel;
				age_q      <= '0;
			end else if (cmd == CMD_TICK && age_q != 16'hFFFF) begin
				age_q <= age_q + 16'd1;
			end
		end
	end

	// divider operand select
	always_comb begin
		div_load = 1'b1;
		case (op)
			OP_LOAD_V: begin
				div_a = clamp_mag(held_lin_q, cfg.lin_limit);
				div_d = cfg.lin_limit;
			end
			OP_SAVE_V: begin
				div_a = clamp_mag(held_ang_q, cfg.ang_limit);
				div_d = cfg.ang_limit;
			end
			OP_SAVE_W: begin
				div_a = {7'd0, cfg.pwm_floor};
				div_d = {7'd0, cfg.pwm_full};
			end
			default: begin
				div_load = 1'b0;
				div_a    = '0;
				div_d    = '0;
			end
		endcase
	end

	// one restoring step; the first step has no shift
	always_comb begin
		trial    = (cnt_q == DIV_LAST) ? {1'b0, rem_q} : {rem_q, 1'b0};
		trial_ge = trial >= {1'b0, den_q};
	end

	// shared iterative divider, a * 2^14 / d with a not above d
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (div_load) begin
			cnt_q <= DIV_LAST;
		end else if (op == OP_DIV && cnt_q != '0) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			rem_q <= div_a;
			den_q <= div_d;
			quo_q <= '0;
		end else if (op == OP_DIV) begin
			rem_q <= trial_ge ? 15'(trial - {1'b0, den_q}) : trial[14:0];
			quo_q <= {quo_q[13:0], trial_ge};
		end
	end

	// mixing and floor arithmetic
	always_comb begin
		vn_new = signed_q(held_lin_q[15], quo_q, cfg.lin_limit);
		wn_new = signed_q(held_ang_q[15], quo_q, cfg.ang_limit);
		diff   = 17'(vn_q) - 17'(wn_new);
		sum    = 17'(vn_q) + 17'(wn_new);
		level  = (cfg.pwm_floor > cfg.pwm_full) ? Q_ONE : quo_q;
	end

	// result registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD_V: stop_q <= 1'b0;
			OP_SAVE_V: vn_q <= vn_new;
			OP_SAVE_W: begin
				left_q  <= sat_one(diff);
				right_q <= sat_one(sum);
			end
			OP_FLOOR: begin
				left_q  <= apply_floor(left_q, level);
				right_q <= apply_floor(right_q, level);
			end
			OP_STOP: begin
				stop_q  <= 1'b1;
				left_q  <= '0;
				right_q <= '0;
			end
			default: ;
		endcase
	end

	assign stat.timeout   = age_q > cfg.timeout;
	assign stat.div_busy  = cnt_q != '0;
	assign stat.floor_off = (cfg.pwm_full == '0) || (cfg.pwm_floor == '0);

	assign res_stop  = stop_q;
	assign res_left  = left_q;
	assign res_right = right_q;

endmodule

`default_nettype wire

/* hw/rtl/diff_drive_mixer_with_watchdog.sv */
// Differential-drive mixer with a command watchdog.
// Input channel (in_valid/in_ready) carries cmd, lin_vel, ang_vel. cmd NEW stores
// the velocity command and clears the tick age; cmd TICK ages the command by one
// (saturating); cmd CTRL produces one item on the output channel; code 3 is dropped.
// NEW and TICK items give no output; the program stays at its wait step.
// A CTRL item runs a short control program: two normalizing divisions and one
// floor-level division on a shared 15-step restoring divider, one quotient bit
// per cycle; the floor division is skipped when the PWM floor is off, and a
// timeout skips to the stop step; emit loads the output, then return leads to wait.
// Output (out_valid/out_ready) carries stopped, left_drive, right_drive in Q1.14.
// The output register holds the item until taken; if the previous item is still
// pending, the program waits at its emit step and no input is taken meanwhile.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and
// should be written only while the block is idle; unknown indexes are ignored.
// Reset clears the held command and the age, loads the register defaults and
// returns the program to its wait step with no output pending.
`default_nettype none

module diff_drive_mixer_with_watchdog
	import ddm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [15:0] lin_vel,
	input  wire logic signed [15:0] ang_vel,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    stopped,
	output logic signed [15:0]      left_drive,
	output logic signed [15:0]      right_drive,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	logic [3:0]         pc_q;
	logic [3:0]         pc_d;
	ctrl_word_t         cw;
	cfg_t               cfg_q;
	dp_stat_t           stat;
	logic               in_fire;
	logic               start;
	logic               out_busy;
	logic               out_load;
	logic               jump;
	logic               res_stop;
	logic signed [15:0] res_left;
	logic signed [15:0] res_right;
	logic               out_valid_q;
	logic               stopped_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lin_limit <= 15'd2048;
			cfg_q.ang_limit <= 15'd4096;
			cfg_q.pwm_full  <= 8'd200;
			cfg_q.pwm_floor <= 8'd0;
			cfg_q.timeout   <= 16'd500;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIN_LIMIT: cfg_q.lin_limit <= cfg_data[14:0];
				REG_ANG_LIMIT: cfg_q.ang_limit <= cfg_data[14:0];
				REG_PWM_FULL:  cfg_q.pwm_full  <= cfg_data[7:0];
				REG_PWM_FLOOR: cfg_q.pwm_floor <= cfg_data[7:0];
				REG_TIMEOUT:   cfg_q.timeout   <= cfg_data;
				default: ;
			endcase
		end
	end

	ddm_urom u_urom (
		.pc (pc_q),
		.cw (cw)
	);

	// input handshake lives in the wait step
	assign in_ready = (cw.op == OP_WAIT);
	assign in_fire  = in_valid && in_ready;
	assign start    = in_fire && (cmd == CMD_CTRL);
	assign out_busy = out_valid_q && !out_ready;
	assign out_load = (cw.op == OP_EMIT) && !out_busy;

	// sequencer: jump on condition, else next step
	always_comb begin
		case (cw.cond)
			C_NEXT:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_START:  jump = !start;
			C_TIMEOUT:   jump = stat.timeout;
			C_DIV_BUSY:  jump = stat.div_busy;
			C_FLOOR_OFF: jump = stat.floor_off;
			C_OUT_BUSY:  jump = out_busy;
			default:     jump = 1'b1;
		endcase
		pc_d = jump ? cw.target : pc_q + 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= ST_WAIT;
		else
			pc_q <= pc_d;
	end

	ddm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (cw.op),
		.cfg       (cfg_q),
		.in_fire   (in_fire),
		.cmd       (cmd),
		.lin_vel   (lin_vel),
		.ang_vel   (ang_vel),
		.stat      (stat),
		.res_stop  (res_stop),
		.res_left  (res_left),
		.res_right (res_right)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			stopped_q <= res_stop;
			left_q    <= res_left;
			right_q   <= res_right;
		end
	end

	assign out_valid   = out_valid_q;
	assign stopped     = stopped_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;

`ifndef SYNTH
	// a stopped item carries zero drives
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stopped |-> left_drive == 16'sd0 && right_drive == 16'sd0)
		else $error("stopped item with nonzero drive");

	// drives stay within +-1.0
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_drive >= -16'sd16384 && left_drive <= 16'sd16384
			&& right_drive >= -16'sd16384 && right_drive <= 16'sd16384)
		else $error("drive out of range");

	// a control step leaves the wait step
	a_ctrl_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_CTRL |=> !in_ready)
		else $error("input taken during control step");
`endif

endmodule

`default_nettype wire
